FILE: sv/mips_subset_single_cycle_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the MIPS subset core
// Shared concurrent-assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

// implication checked every clock, masked while reset is low
`define MSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/msc_pkg.sv
// ---------------------------------------------------------------------------
// msc_pkg
// Types and constants shared by the MIPS subset core.
// ---------------------------------------------------------------------------
`default_nettype none
package msc_pkg;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] STACK_TOP_RESET = 32'h0100_0000;
    localparam logic [31:0] PC_HI_MASK      = 32'hF000_0000;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_MUL  = 6'd24;
    localparam logic [5:0] FN_DIV  = 6'd26;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_SLT  = 6'd42;

    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_ALIGN = 2'd1;
    localparam logic [1:0] FLT_FETCH = 2'd2;
    localparam logic [1:0] FLT_DATA  = 2'd3;

    localparam logic [1:0] CLS_NOP = 2'd0;
    localparam logic [1:0] CLS_R   = 2'd1;
    localparam logic [1:0] CLS_I   = 2'd2;
    localparam logic [1:0] CLS_J   = 2'd3;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    // register-file port request
    typedef struct packed {
        logic        we;
        logic [4:0]  waddr;
        logic [31:0] wdata;
        logic [4:0]  ra;
        logic [4:0]  rb;
    } msc_rf_req_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } msc_div_req_t;

    function automatic logic less_signed(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) < $signed(b));
    endfunction
endpackage
`default_nettype wire

FILE: sv/mips_subset_single_cycle_core.sv
// ---------------------------------------------------------------------------
// mips_subset_single_cycle_core
// MIPS32 subset core stepped one transaction at a time.
// ---------------------------------------------------------------------------
// Each input transaction either stores one word into memory (func 0) or
// executes the instruction at the PC (func 1), and yields one result
// transaction. Word memory is a single-port synchronous RAM with registered
// read data; the register file has two registered read ports. A load
// transaction goes from accept straight to result; an instruction steps
// through accept and fetch issue, fetch, register read, execute/memory and
// write back, lw/sw add a state for the data access, and div adds a wait
// for the bit-serial divider. Fetch faults and the halted state also go
// from accept straight to result. One item is in flight at a time; the
// result sits in an output register so the next item may be accepted while
// it waits. No clearing pass after reset: reads of never-written memory words
// are undefined.
// ---------------------------------------------------------------------------
`default_nettype none
`include "mips_subset_single_cycle_core_macros.svh"
module mips_subset_single_cycle_core
    import msc_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 22
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config: stack_top
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    // in: [0] func, [22:1] load_addr, [54:23] load_data, [55] pad
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,
    // out: [31:0] next_pc, [32] halted, [34:33] fault, [36:35] instr_class,
    //      [37] reg_written, [42:38] reg_index, [74:43] reg_value,
    //      [75] mem_accessed, [107:76] result_value, [111:108] pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata
);
    localparam int MW = MEM_ADDR_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_DIV, S_DONE
    } state_t;

    state_t       state_reg;
    logic [31:0]  pc_reg, ir_reg;
    logic         m_tvalid_reg;
    logic [111:0] m_tdata_reg;

    // memory
    logic [31:0] mem [2**MW];
    logic        mem_we;
    logic [MW-1:0] mem_addr;
    logic [31:0] mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    // regfile
    msc_rf_req_t rf_req;
    logic [31:0] rd_a, rd_b, v0;
    logic        sp_we;

    msc_regfile u_rf (
        .aclk(aclk), .aresetn(aresetn), .req(rf_req), .sp_we(sp_we),
        .sp_data(cfg_data), .rd_a(rd_a), .rd_b(rd_b), .v0(v0)
    );

    msc_div_req_t div_req;
    logic         div_done;
    logic [31:0]  div_q;

    msc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .done(div_done),
        .quotient(div_q)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign sp_we     = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;

    // decode fields
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, pc4, ea;
    assign op  = ir_reg[31:26];
    assign rs  = ir_reg[25:21];
    assign rt  = ir_reg[20:16];
    assign rd  = ir_reg[15:11];
    assign sh  = ir_reg[10:6];
    assign fn  = ir_reg[5:0];
    assign imm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign pc4 = pc_reg + 32'd4;
    assign ea  = rd_a + imm;

    logic ea_oob, pc_oob;
    assign ea_oob = (ea[31:2] >> MW) != 30'd0;
    assign pc_oob = (pc_reg[31:2] >> MW) != 30'd0;

    logic        acc;
    logic        in_func;
    logic [21:0] in_addr;
    logic [31:0] in_data;
    logic        ld_oob;
    assign acc     = s_tvalid && s_tready;
    assign in_func = s_tdata[0];
    assign in_addr = s_tdata[22:1];
    assign in_data = s_tdata[54:23];
    assign ld_oob  = (in_addr >> MW) != 22'd0;

    // result registers
    logic [1:0]  fault_reg, cls_reg;
    logic        macc_reg;
    logic        dst_reg;
    logic [4:0]  di_reg;
    logic [31:0] dv_reg, npc_reg;

    // result handed to the output register this cycle
    logic        done_fire;
    assign done_fire = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // execute-stage combinational outcome
    logic        x_dst, x_div, x_mem;
    logic [4:0]  x_di;
    logic [31:0] x_dv, x_npc;
    logic [1:0]  x_cls, x_fault;

    always_comb begin
        x_dst = 1'b0; x_di = '0; x_dv = '0; x_npc = pc4;
        x_div = 1'b0; x_mem = 1'b0; x_fault = FLT_NONE;
        x_cls = CLS_I;
        unique case (op)
            OP_RTYPE: begin
                x_cls = (ir_reg == 32'd0) ? CLS_NOP : CLS_R;
                x_dst = 1'b1;
                x_di  = rd;
                case (fn)
                    FN_ADD, FN_ADDU: x_dv = rd_a + rd_b;
                    FN_SUB, FN_SUBU: x_dv = rd_a - rd_b;
                    FN_AND: x_dv = rd_a & rd_b;
                    FN_OR:  x_dv = rd_a | rd_b;
                    FN_SLT: x_dv = {31'd0, less_signed(rd_a, rd_b)};
                    FN_SLL: x_dv = rd_b << sh;
                    FN_SRL: x_dv = rd_b >> sh;
                    FN_MUL: x_dv = rd_a * rd_b;
                    FN_DIV: x_div = 1'b1;
                    FN_JR: begin
                        x_npc = rd_a;
                        x_dst = 1'b0;
                    end
                    default: x_dst = 1'b0;
                endcase
            end
            OP_J, OP_JAL: begin
                x_cls = CLS_J;
                x_npc = {4'd0, ir_reg[25:0], 2'b00} | (pc4 & PC_HI_MASK);
                if (op == OP_JAL) begin
                    x_dst = 1'b1; x_di = REG_RA; x_dv = pc4;
                end
            end
            OP_BEQ: if (rd_a == rd_b) x_npc = pc4 + {imm[29:0], 2'b00};
            OP_BNE: if (rd_a != rd_b) x_npc = pc4 + {imm[29:0], 2'b00};
            OP_ADDI, OP_ADDIU: begin
                x_dst = 1'b1; x_di = rt; x_dv = rd_a + imm;
            end
            OP_SLTI: begin
                x_dst = 1'b1; x_di = rt; x_dv = {31'd0, less_signed(rd_a, imm)};
            end
            OP_LW, OP_SW: begin
                if (ea_oob) x_fault = FLT_DATA;
                else x_mem = 1'b1;
            end
            default: ;
        endcase
    end

    // memory port and regfile request muxing
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = pc_reg[MW+1:2];
        mem_wdata = rd_b;
        if (state_reg == S_IDLE && acc && !in_func) begin
            mem_we    = !ld_oob;
            mem_addr  = MW'(in_addr);
            mem_wdata = in_data;
        end else if (state_reg == S_EXEC && x_mem) begin
            mem_we   = (op == OP_SW);
            mem_addr = ea[MW+1:2];
        end
        rf_req.ra    = rs;
        rf_req.rb    = rt;
        rf_req.we    = (state_reg == S_DONE) && dst_reg;
        rf_req.waddr = di_reg;
        rf_req.wdata = dv_reg;
        if (state_reg == S_FETCH) begin
            rf_req.ra = mem_rdata[25:21];
            rf_req.rb = mem_rdata[20:16];
        end
        div_req.start    = (state_reg == S_EXEC) && x_div;
        div_req.dividend = rd_a;
        div_req.divisor  = rd_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (done_fire) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (acc) begin
                    cls_reg <= CLS_NOP;
                    dst_reg <= 1'b0; di_reg <= '0; dv_reg <= '0;
                    macc_reg <= 1'b0; npc_reg <= pc_reg;
                    if (!in_func) begin
                        fault_reg <= ld_oob ? FLT_DATA : FLT_NONE;
                        state_reg <= S_DONE;
                    end else if (pc_reg == ALL_ONES) begin
                        fault_reg <= FLT_NONE; state_reg <= S_DONE;
                    end else if (pc_reg[1:0] != 2'b00) begin
                        fault_reg <= FLT_ALIGN; state_reg <= S_DONE;
                    end else if (pc_oob) begin
                        fault_reg <= FLT_FETCH; state_reg <= S_DONE;
                    end else begin
                        fault_reg <= FLT_NONE; state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    ir_reg    <= mem_rdata;
                    state_reg <= S_DECODE;
                end
                S_DECODE: state_reg <= S_EXEC;
                S_EXEC: begin
                    cls_reg <= x_cls; fault_reg <= x_fault; npc_reg <= x_npc;
                    dst_reg <= x_dst; di_reg <= x_di; dv_reg <= x_dv;
                    macc_reg <= x_mem;
                    if (x_div) state_reg <= S_DIV;
                    else if (x_mem) state_reg <= S_MEM;
                    else state_reg <= S_DONE;
                end
                S_MEM: begin
                    if (op == OP_LW) begin
                        dst_reg <= 1'b1; di_reg <= rt; dv_reg <= mem_rdata;
                    end
                    state_reg <= S_DONE;
                end
                S_DIV: if (div_done) begin
                    dv_reg <= div_q; state_reg <= S_DONE;
                end
                S_DONE: if (done_fire) begin
                    pc_reg    <= npc_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result payload; v0 is sampled after the write-back lands
    logic        wr_now;
    assign wr_now = dst_reg && (di_reg != 5'd0);
    logic [31:0] v0_after;
    assign v0_after = (wr_now && di_reg == REG_V0) ? dv_reg : v0;

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            m_tdata_reg <= {4'd0, v0_after, macc_reg,
                            wr_now ? dv_reg : 32'd0, wr_now ? di_reg : 5'd0, wr_now,
                            cls_reg, fault_reg, npc_reg == ALL_ONES, npc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MSC_ASSERT_IMP(a_one_inflight, aclk, aresetn, acc, state_reg == S_IDLE, "accept while busy")
    `MSC_ASSERT_NXT(a_done_valid, aclk, aresetn, done_fire, m_tvalid, "result not shown")
    `MSC_ASSERT_IMP(a_wr_idx, aclk, aresetn, m_tvalid && m_tdata[37], m_tdata[42:38] != 5'd0, "write to zero register")
    `MSC_ASSERT_IMP(a_cfg_idle, aclk, aresetn, sp_we, !acc, "config during accept")
endmodule
`default_nettype wire

FILE: sv/msc_regfile.sv
// ---------------------------------------------------------------------------
// msc_regfile
// 32x32 register file: synchronous write, two registered reads, $v0 tap.
// Reset value held via valid bits; $zero reads zero.
// ---------------------------------------------------------------------------
`default_nettype none
module msc_regfile
    import msc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire msc_rf_req_t req,
    input  wire logic        sp_we,
    input  wire logic [31:0] sp_data,
    output logic [31:0]      rd_a,
    output logic [31:0]      rd_b,
    output logic [31:0]      v0
);
    logic [31:0] regs_reg [32];
    logic [31:0] vld_reg;
    logic [31:0] rd_a_reg, rd_b_reg;

    // $sp starts at the default stack top, $ra at all ones
    function automatic logic [31:0] rst_val(input logic [4:0] i);
        logic [31:0] r;
        r = '0;
        if (i == REG_RA) r = ALL_ONES;
        if (i == REG_SP) r = STACK_TOP_RESET;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (req.we && req.waddr != 5'd0) begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (sp_we) begin
                vld_reg[REG_SP] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.we && req.waddr != 5'd0) begin
            regs_reg[req.waddr] <= req.wdata;
        end
        if (sp_we) begin
            regs_reg[REG_SP] <= sp_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= (req.ra == 5'd0) ? '0 :
                    (vld_reg[req.ra] ? regs_reg[req.ra] : rst_val(req.ra));
        rd_b_reg <= (req.rb == 5'd0) ? '0 :
                    (vld_reg[req.rb] ? regs_reg[req.rb] : rst_val(req.rb));
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;
    assign v0   = vld_reg[REG_V0] ? regs_reg[REG_V0] : '0;
endmodule
`default_nettype wire

FILE: sv/msc_divider.sv
// ---------------------------------------------------------------------------
// msc_divider
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module msc_divider
    import msc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire msc_div_req_t req,
    output logic              done,
    output logic [31:0]       quotient
);
    logic [31:0] q_reg, d_reg;
    logic [32:0] r_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {r_reg[31:0], q_reg[31]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                q_reg    <= req.dividend;
                d_reg    <= req.divisor;
                r_reg    <= '0;
            end else if (busy_reg) begin
                if (trial[32]) begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[30:0], 1'b0};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // zero divisor already yields all ones from restoring steps
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire
